[rtl/mpq_pkg.sv]
// Package for the min priority queue: constants, codes and cell types.
package mpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int OCC_W           = 5;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] rank;
    } t_entry;

    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry new_entry;
    } t_cell_ctl;

    typedef struct packed {
        logic   valid;
        logic   ins;
        t_entry entry;
    } t_cell_link;

endpackage

[rtl/mpq_in_if.sv]
// Request channel of the min priority queue.
interface mpq_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic signed [mpq_pkg::DATA_W-1:0]   item_value;
    logic signed [mpq_pkg::DATA_W-1:0]   item_rank;

    modport source (output valid, output func, output item_value, output item_rank,
                    input ready);
    modport sink   (input valid, input func, input item_value, input item_rank,
                    output ready);
endinterface

[rtl/mpq_out_if.sv]
// Result channel of the min priority queue.
interface mpq_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mpq_pkg::DATA_W-1:0]   out_value;
    logic signed [mpq_pkg::DATA_W-1:0]   out_rank;
    logic                                removed_valid;
    logic [1:0]                          status_code;
    logic [mpq_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output out_value, output out_rank,
                    output removed_valid, output status_code, output occupancy,
                    input ready);
    modport sink   (input valid, input out_value, input out_rank,
                    input removed_valid, input status_code, input occupancy,
                    output ready);
endinterface

[rtl/mpq_cell.sv]
// One sorted cell of the queue chain: holds an entry and shifts with its neighbors.
module mpq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mpq_pkg::t_cell_ctl  i_ctl,
    input  mpq_pkg::t_cell_link i_left,
    input  mpq_pkg::t_cell_link i_right,
    output mpq_pkg::t_cell_link o_link
);

    logic            r_valid;
    logic            n_valid;
    mpq_pkg::t_entry r_entry;
    mpq_pkg::t_entry n_entry;
    logic            w_ins;

    assign w_ins  = !r_valid || (r_entry.rank > i_ctl.new_entry.rank);
    assign o_link = '{valid: r_valid, ins: w_ins, entry: r_entry};

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (i_left.ins) begin
                n_valid = i_left.valid;
                n_entry = i_left.entry;
            end else if (w_ins) begin
                n_valid = 1'b1;
                n_entry = i_ctl.new_entry;
            end
        end else if (i_ctl.deq) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[rtl/min_priority_queue_top.sv]
// Top level of the min priority queue: sorted cell chain, count and result register.
//
//  channel  | modport | beat contents
//  ---------+---------+------------------------------------------------------
//  i_req    | sink    | func, item_value, item_rank
//  o_rsp    | source  | out_value, out_rank, removed_valid, status_code, occupancy
//
//  On enqueue each cell compares its rank with the new one and later cells shift;
//  dequeue shifts all to the head. The chain stays sorted; the head is the minimum.
//  One request beat per cycle while the result register drains at the same rate.
//  Reset empties the chain at once; no clearing pass is needed.
//  A stalled result holds the request side until the result register frees.
module min_priority_queue_top #(
    parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mpq_in_if.sink   i_req,
    mpq_out_if.source o_rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mpq_pkg::t_cell_link w_link [QUEUE_DEPTH];
    mpq_pkg::t_cell_link w_head_src;
    mpq_pkg::t_cell_link w_tail_src;
    mpq_pkg::t_cell_ctl  w_ctl;

    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                n_count;
    logic                            w_accept;
    logic                            w_full;
    logic                            w_empty;
    logic [CNT_W+mpq_pkg::OCC_W-1:0] w_count_ext;

    logic                               r_out_valid;
    logic signed [mpq_pkg::DATA_W-1:0]  r_out_value;
    logic signed [mpq_pkg::DATA_W-1:0]  r_out_rank;
    logic                               r_out_removed;
    mpq_pkg::t_status                   r_out_status;
    logic [mpq_pkg::OCC_W-1:0]          r_out_occ;

    logic signed [mpq_pkg::DATA_W-1:0]  n_out_value;
    logic signed [mpq_pkg::DATA_W-1:0]  n_out_rank;
    logic                               n_out_removed;
    mpq_pkg::t_status                   n_out_status;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);

    assign w_ctl.enq       = w_accept && (i_req.func == mpq_pkg::FUNC_ENQ) && !w_full;
    assign w_ctl.deq       = w_accept && (i_req.func == mpq_pkg::FUNC_DEQ) && !w_empty;
    assign w_ctl.new_entry = '{value: i_req.item_value, rank: i_req.item_rank};

    assign w_head_src = '{valid: 1'b1, ins: 1'b0, entry: '0};
    assign w_tail_src = '{valid: 1'b0, ins: 1'b1, entry: '0};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            mpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_head_src),
                .i_right (w_link[g+1]),
                .o_link  (w_link[g])
            );
        end else if (g == QUEUE_DEPTH - 1) begin : g_last
            mpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_link[g-1]),
                .i_right (w_tail_src),
                .o_link  (w_link[g])
            );
        end else begin : g_mid
            mpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_link[g-1]),
                .i_right (w_link[g+1]),
                .o_link  (w_link[g])
            );
        end
    end

    always_comb begin
        n_count       = r_count;
        n_out_value   = '0;
        n_out_rank    = '0;
        n_out_removed = 1'b0;
        n_out_status  = mpq_pkg::STATUS_OK;
        case (i_req.func)
            mpq_pkg::FUNC_ENQ: begin
                if (w_full) begin
                    n_out_status = mpq_pkg::STATUS_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            mpq_pkg::FUNC_DEQ: begin
                if (w_empty) begin
                    n_out_status = mpq_pkg::STATUS_EMPTY;
                end else begin
                    n_count       = r_count - CNT_W'(1);
                    n_out_value   = w_link[0].entry.value;
                    n_out_rank    = w_link[0].entry.rank;
                    n_out_removed = 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_count_ext = {{mpq_pkg::OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_value   <= n_out_value;
            r_out_rank    <= n_out_rank;
            r_out_removed <= n_out_removed;
            r_out_status  <= n_out_status;
            r_out_occ     <= w_count_ext[mpq_pkg::OCC_W-1:0];
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.out_value     = r_out_value;
    assign o_rsp.out_rank      = r_out_rank;
    assign o_rsp.removed_valid = r_out_removed;
    assign o_rsp.status_code   = r_out_status;
    assign o_rsp.occupancy     = r_out_occ;

endmodule
